// ----- rtl/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding-window median filter
// Flag and control structures passed between the top level and the cells.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int CFG_W     = 7;
  localparam int LEN_RESET = 3;

  // Status that each cell shows to its neighbours.
  typedef struct packed {
    logic above;   // empty, or holds a value greater than the incoming sample
    logic oldest;  // holds the sample that leaves the window on this word
  } cell_flags_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic upd;     // a word is accepted in this cycle
    logic full;    // the window was already full before this word
  } cell_ctl_t;

endpackage

// ----- rtl/swm_cell.sv -----
// ----------------------------------------------------------------------------
// swm_cell: one slot of the sorted window
// Holds one sample and its age, and on each accepted word takes its new
// contents from itself, a neighbour or the incoming sample.
// ----------------------------------------------------------------------------
module swm_cell #(
  parameter int SW  = 16,
  parameter int AW  = 6,
  parameter int LW  = 7,
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  swm_pkg::cell_ctl_t   ctl,
  input  logic [LW-1:0]        fill,
  input  logic [AW-1:0]        len_m1,
  input  logic [SW-1:0]        sample,
  input  logic                 below_old,
  input  logic [SW-1:0]        lo_value,
  input  logic [AW-1:0]        lo_age,
  input  swm_pkg::cell_flags_t lo_flags,
  input  logic [SW-1:0]        up_value,
  input  logic [AW-1:0]        up_age,
  input  swm_pkg::cell_flags_t up_flags,
  output logic [SW-1:0]        value,
  output logic [AW-1:0]        age,
  output swm_pkg::cell_flags_t flags
);
  import swm_pkg::*;

  logic [SW-1:0] value_r, value_nxt;
  logic [AW-1:0] age_r, age_nxt;
  logic          occ;
  logic          shift_here;
  logic [SW-1:0] w_val, wm_val;
  logic [AW-1:0] w_age, wm_age;
  logic          w_above, wm_above;

  assign occ          = LW'(IDX) < fill;
  assign flags.above  = !occ || ($signed(value_r) > $signed(sample));
  assign flags.oldest = occ && ctl.full && (age_r == len_m1);

  // Once the oldest entry has been taken out, everything from its slot
  // upwards moves down by one place.
  assign shift_here = below_old || flags.oldest;
  assign w_val      = shift_here ? up_value       : value_r;
  assign w_age      = shift_here ? up_age         : age_r;
  assign w_above    = shift_here ? up_flags.above : flags.above;
  assign wm_val     = below_old  ? value_r        : lo_value;
  assign wm_age     = below_old  ? age_r          : lo_age;
  assign wm_above   = below_old  ? flags.above    : lo_flags.above;

  always_comb begin
    value_nxt = value_r;
    age_nxt   = age_r;
    if (ctl.upd) begin
      priority if (!w_above) begin
        value_nxt = w_val;
        age_nxt   = w_age + AW'(1);
      end else if (!wm_above) begin
        value_nxt = sample;
        age_nxt   = '0;
      end else begin
        value_nxt = wm_val;
        age_nxt   = wm_age + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    age_r   <= age_nxt;
  end

  assign value = value_r;
  assign age   = age_r;

endmodule

// ----- rtl/swm_pick.sv -----
// ----------------------------------------------------------------------------
// swm_pick: median selection and output register
// Picks the two middle cells through an AND-OR tree and registers their sum.
// ----------------------------------------------------------------------------
module swm_pick #(
  parameter int N  = 64,
  parameter int SW = 16,
  parameter int LW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  logic          out_stall,
  input  logic [LW-1:0] len,
  input  logic [SW-1:0] vals [N],
  output logic          out_valid,
  output logic [SW:0]   median_x2
);
  import swm_pkg::*;

  localparam int P = 1 << $clog2(N);

  logic [LW-1:0] lo_idx, hi_idx;
  logic [SW-1:0] lo_t [2*P-1];
  logic [SW-1:0] hi_t [2*P-1];
  logic          out_valid_r, out_valid_nxt;
  logic [SW:0]   median_r, median_nxt;

  assign lo_idx = (len - LW'(1)) >> 1;
  assign hi_idx = len >> 1;

  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < N) begin : g_used
      assign lo_t[P-1+i] = (LW'(i) == lo_idx) ? vals[i] : '0;
      assign hi_t[P-1+i] = (LW'(i) == hi_idx) ? vals[i] : '0;
    end else begin : g_pad
      assign lo_t[P-1+i] = '0;
      assign hi_t[P-1+i] = '0;
    end
  end

  for (genvar k = 0; k < P - 1; k++) begin : g_node
    assign lo_t[k] = lo_t[2*k+1] | lo_t[2*k+2];
    assign hi_t[k] = hi_t[2*k+1] | hi_t[2*k+2];
  end

  always_comb begin
    median_nxt    = median_r;
    out_valid_nxt = out_valid_r;
    priority if (load) begin
      median_nxt    = {lo_t[0][SW-1], lo_t[0]} + {hi_t[0][SW-1], hi_t[0]};
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    median_r <= median_nxt;
  end

  assign out_valid = out_valid_r;
  assign median_x2 = median_r;

endmodule

// ----- rtl/sliding_window_median.sv -----
// ----------------------------------------------------------------------------
// sliding_window_median: sliding-window median filter
// The row of cells takes a sample word, and the output register then loads
// its median. Throughput: one word per cycle, set by the remove-and-insert
// across the row of cells; a stalled result holds the next one back.
// Reset (synchronous, active low) empties the window and sets its length to
// three; no clearing pass is needed, the fill count guards the cells.
// ----------------------------------------------------------------------------
module sliding_window_median #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [swm_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [SAMPLE_BITS-1:0]   in_sample,
  input  logic                     in_first,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [SAMPLE_BITS:0]     out_median_x2
);
  import swm_pkg::*;

  localparam int N       = WINDOW_MAX;
  localparam int SW      = SAMPLE_BITS;
  localparam int AW      = $clog2(N);
  localparam int LW      = $clog2(N + 1);
  localparam int L       = $clog2(N);
  localparam int LEN_RST = (N < LEN_RESET) ? N : LEN_RESET;

  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] fill_r, fill_nxt;
  logic          pend_r, pend_nxt;
  logic [LW-1:0] eff_fill, len_clamp;
  logic [AW-1:0] len_m1;
  logic          accept, move, full, emit;
  cell_ctl_t     ctl;

  logic [SW-1:0] cell_val   [N];
  logic [AW-1:0] cell_age   [N];
  cell_flags_t   cell_flags [N];
  logic [N-1:0]  pfx        [L+1];

  assign move     = pend_r && (!out_valid || !out_stall);
  assign in_stall = pend_r && !move;
  assign accept   = in_valid && !in_stall;

  assign eff_fill = in_first ? '0 : fill_r;
  assign full     = (eff_fill == len_r);
  assign emit     = full || ((eff_fill + LW'(1)) == len_r);
  assign len_m1   = AW'(len_r - LW'(1));
  assign ctl.upd  = accept;
  assign ctl.full = full;

  always_comb begin
    priority if (cfg_wdata == '0) begin
      len_clamp = LW'(1);
    end else if (32'(cfg_wdata) > N) begin
      len_clamp = LW'(N);
    end else begin
      len_clamp = LW'(cfg_wdata);
    end
  end

  always_comb begin
    len_nxt  = len_r;
    fill_nxt = fill_r;
    pend_nxt = move ? 1'b0 : pend_r;
    priority if (cfg_we) begin
      len_nxt  = len_clamp;
      fill_nxt = '0;
    end else if (accept) begin
      fill_nxt = full ? eff_fill : eff_fill + LW'(1);
      pend_nxt = emit;
    end else begin
      fill_nxt = fill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= LW'(LEN_RST);
      fill_r <= '0;
      pend_r <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      fill_r <= fill_nxt;
      pend_r <= pend_nxt;
    end
  end

  // Each cell must know whether the leaving entry sits below it: a
  // log-depth prefix OR over the oldest flags.
  for (genvar i = 0; i < N; i++) begin : g_pfx0
    assign pfx[0][i] = cell_flags[i].oldest;
  end
  for (genvar l = 0; l < L; l++) begin : g_lvl
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i >= (1 << l)) begin : g_or
        assign pfx[l+1][i] = pfx[l][i] | pfx[l][i-(1<<l)];
      end else begin : g_pass
        assign pfx[l+1][i] = pfx[l][i];
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [SW-1:0] lo_v, up_v;
    logic [AW-1:0] lo_a, up_a;
    cell_flags_t   lo_f, up_f;
    logic          below;

    if (i == 0) begin : g_bottom
      assign lo_v  = '0;
      assign lo_a  = '0;
      assign lo_f  = '{above: 1'b0, oldest: 1'b0};
      assign below = 1'b0;
    end else begin : g_lower
      assign lo_v  = cell_val[i-1];
      assign lo_a  = cell_age[i-1];
      assign lo_f  = cell_flags[i-1];
      assign below = pfx[L][i-1];
    end

    if (i == N - 1) begin : g_top
      assign up_v = '0;
      assign up_a = '0;
      assign up_f = '{above: 1'b1, oldest: 1'b0};
    end else begin : g_upper
      assign up_v = cell_val[i+1];
      assign up_a = cell_age[i+1];
      assign up_f = cell_flags[i+1];
    end

    swm_cell #(
      .SW (SW),
      .AW (AW),
      .LW (LW),
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .fill     (eff_fill),
      .len_m1   (len_m1),
      .sample   (in_sample),
      .below_old(below),
      .lo_value (lo_v),
      .lo_age   (lo_a),
      .lo_flags (lo_f),
      .up_value (up_v),
      .up_age   (up_a),
      .up_flags (up_f),
      .value    (cell_val[i]),
      .age      (cell_age[i]),
      .flags    (cell_flags[i])
    );
  end

  swm_pick #(
    .N (N),
    .SW(SW),
    .LW(LW)
  ) u_pick (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (move),
    .out_stall(out_stall),
    .len      (len_r),
    .vals     (cell_val),
    .out_valid(out_valid),
    .median_x2(out_median_x2)
  );

endmodule

// ----- rtl/swm_checker.sv -----
// ----------------------------------------------------------------------------
// swm_checker: port-level checks for the median filter
// Watches the handshakes of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module swm_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [SAMPLE_BITS:0] out_median_x2
);

  // A result word that is held back keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_median_x2))
    else $error("result word changed while stalled");

  // The input only waits behind a result that is itself held back.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // A fresh result must come from a sample word that was taken before it.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result word without a sample word behind it");

  // Reset leaves no result word pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind sliding_window_median swm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_swm_checker (.*);

// ----- sim/sliding_window_median_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_median_test: self-checking bench for the median filter
// Drives sample words with random gaps, and the receiver stalls at random.
// It mirrors the sorted window and the arrival ring, and checks every median
// word in order. The window length is changed between phases, including
// zero and lengths above the maximum.
// ----------------------------------------------------------------------------
module sliding_window_median_test;

  import swm_pkg::*;

  localparam int WIN_MAX      = 64;
  localparam int SMP_BITS     = 16;
  localparam int SETTLE       = 8;     // cycles after the last median before a register write
  localparam int STUCK_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASES       = 12;

  // Columns: sample, first, median typed in, typed median (twice the value).
  typedef struct packed {
    logic [SMP_BITS-1:0] sample;
    logic                first;
    logic                typed;
    logic [SMP_BITS:0]   median;
  } dir_row_t;

  localparam int DIR_ROWS = 21;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    {16'h7FFF, 1'b1, 1'b0, 17'h00000},
    {16'h7FFF, 1'b0, 1'b0, 17'h00000},
    {16'h7FFF, 1'b0, 1'b1, 17'h0FFFE},
    {16'h8000, 1'b0, 1'b0, 17'h00000},
    {16'h8000, 1'b0, 1'b0, 17'h00000},
    {16'h8000, 1'b0, 1'b1, 17'h10000},
    {16'h0000, 1'b1, 1'b0, 17'h00000},
    {16'h0001, 1'b0, 1'b0, 17'h00000},
    {16'hFFFF, 1'b0, 1'b1, 17'h00000},
    {16'h0005, 1'b0, 1'b0, 17'h00000},
    {16'h0005, 1'b0, 1'b0, 17'h00000},
    {16'h0005, 1'b0, 1'b1, 17'h0000A},
    {16'hFFF9, 1'b1, 1'b0, 17'h00000},
    {16'h0003, 1'b0, 1'b0, 17'h00000},
    {16'hFFF9, 1'b1, 1'b0, 17'h00000},
    {16'h0002, 1'b0, 1'b0, 17'h00000},
    {16'h0004, 1'b0, 1'b0, 17'h00000},
    {16'h0002, 1'b0, 1'b0, 17'h00000},
    {16'h0002, 1'b0, 1'b0, 17'h00000},
    {16'h5555, 1'b0, 1'b0, 17'h00000},
    {16'hAAAA, 1'b0, 1'b0, 17'h00000}
  };

  localparam logic [CFG_W-1:0] WIN_PLAN [10] = '{
    7'd1, 7'd2, 7'd0, 7'd127, 7'd64, 7'd4, 7'd65, 7'd5, 7'd6, 7'd3
  };

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [SMP_BITS-1:0] in_sample = '0;
  logic                in_first  = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SMP_BITS:0]   out_median_x2;

  // Mirror of the filter state.
  logic signed [SMP_BITS-1:0] arrivals [WIN_MAX];
  logic signed [SMP_BITS-1:0] ordered  [WIN_MAX];
  int unsigned                held;
  int unsigned                oldest_slot;
  logic [CFG_W-1:0]           win_len;

  logic [SMP_BITS:0] expected_medians [$];

  bit          calm      = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stuck     = 0;
  int unsigned samples_sent  = 0;
  int unsigned medians_seen  = 0;
  int unsigned fail_count    = 0;
  logic [SMP_BITS-1:0] last_sample = '0;

  sliding_window_median #(
    .WINDOW_MAX  (WIN_MAX),
    .SAMPLE_BITS (SMP_BITS)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .in_first      (in_first),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_median_x2 (out_median_x2)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int unsigned eff_len(input logic [CFG_W-1:0] v);
    if (v == 0) begin
      return 1;
    end
    if (v > WIN_MAX) begin
      return WIN_MAX;
    end
    return v;
  endfunction

  // Advances the mirror by one sample word; returns 1 when a median follows.
  function automatic bit median_step(input logic signed [SMP_BITS-1:0] s, input bit f,
                                     output logic [SMP_BITS:0] med);
    int unsigned len;
    int unsigned n;
    int unsigned pos;
    int          i;
    bit          found;
    len = eff_len(win_len);
    med = '0;
    if (f) begin
      held = 0;
      oldest_slot = 0;
    end
    if (held > len) held = 0;
    if (oldest_slot >= len) oldest_slot = 0;
    if (held < len) begin
      n = held;
      held++;
    end else begin
      // Drop the leaving sample; if it were somehow absent, the top entry goes.
      pos = held - 1;
      found = 1'b0;
      for (i = 0; i < held; i++) begin
        if (!found && ordered[i] == arrivals[oldest_slot]) begin
          pos = i;
          found = 1'b1;
        end
      end
      for (i = pos; i + 1 < held; i++) ordered[i] = ordered[i+1];
      n = held - 1;
    end
    i = n;
    while (i > 0 && ordered[i-1] > s) begin
      ordered[i] = ordered[i-1];
      i--;
    end
    ordered[i] = s;
    arrivals[oldest_slot] = s;
    oldest_slot++;
    if (oldest_slot >= len) oldest_slot = 0;
    if (held < len) return 1'b0;
    med = {ordered[(len-1)/2][SMP_BITS-1], ordered[(len-1)/2]}
        + {ordered[len/2][SMP_BITS-1], ordered[len/2]};
    return 1'b1;
  endfunction

  function automatic logic [SMP_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 16'($urandom);
      5, 6, 7:       return 16'($urandom_range(0, 8) - 4);
      8:             return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default:       return last_sample;
    endcase
  endfunction

  // Starts just after a rising edge and returns at the edge that takes the word.
  task automatic push_sample(input logic [SMP_BITS-1:0] s, input bit f, input bit typed,
                             input logic [SMP_BITS:0] typed_med);
    logic [SMP_BITS:0] med;
    bit                produced;
    while (!calm && $urandom_range(0, 99) < 25) begin
      @(negedge clk);
      in_valid = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid  = 1'b1;
    in_sample = s;
    in_first  = f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
    produced = median_step(s, f, med);
    if (typed) begin
      expected_medians.insert(expected_medians.size(), typed_med);
    end else if (produced) begin
      expected_medians.insert(expected_medians.size(), med);
    end
  endtask

  task automatic drain_filter();
    @(negedge clk);
    in_valid = 1'b0;
    in_first = 1'b0;
    while (expected_medians.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_window(input logic [CFG_W-1:0] v);
    drain_filter();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    win_len     = v;
    held        = 0;
    oldest_slot = 0;
  endtask

  // Receiver: random stalls, one long hold-off once the stream is running.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall = 1'b1;
    end else if (!hold_done && !calm && medians_seen >= 250) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall = 1'b1;
    end else begin
      out_stall = !calm && ($urandom_range(0, 99) < 25);
    end
  end

  always @(posedge clk) begin
    logic [SMP_BITS:0] want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
      if (stuck >= STUCK_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STUCK_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
      if (out_valid && !out_stall) begin
        medians_seen++;
        if (expected_medians.size() == 0) begin
          $display("%0t: median %0d arrived with none expected", $time,
                   $signed(out_median_x2));
          fail_count++;
        end else begin
          want = expected_medians.pop_front();
          if (want !== out_median_x2) begin
            $display("%0t: median_x2 expected %0d, got %0d", $time, $signed(want),
                     $signed(out_median_x2));
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] len_now;
    int unsigned      words;
    int               p;
    int               k;
    held        = 0;
    oldest_slot = 0;
    win_len     = LEN_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    for (k = 0; k < DIR_ROWS; k++) begin
      push_sample(DIRECTED[k].sample, DIRECTED[k].first, DIRECTED[k].typed,
                  DIRECTED[k].median);
    end

    for (p = 0; p < PHASES; p++) begin
      len_now = (p < 10) ? WIN_PLAN[p] : CFG_W'($urandom_range(1, 127));
      set_window(len_now);
      calm  = (p == 5);
      words = 30 + 2 * eff_len(len_now);
      for (k = 0; k < words; k++) begin
        last_sample = pick_sample();
        push_sample(last_sample, $urandom_range(0, 99) < 2, 1'b0, '0);
      end
      calm = 1'b0;
    end

    drain_filter();
    repeat (SETTLE) @(posedge clk);
    if (expected_medians.size() != 0) begin
      $display("%0t: %0d medians never arrived", $time, expected_medians.size());
      fail_count += expected_medians.size();
    end
    $display("Sent %0d samples over %0d window settings (zero, one, even, odd, 64 and above).",
             samples_sent, PHASES + 1);
    $display("Checked %0d medians, %0d mismatches.", medians_seen, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/swm_pick.sv
rtl/sliding_window_median.sv
rtl/swm_checker.sv
sim/sliding_window_median_test.sv
